@@ rtl/pwm_period_duty_measure_core_macros.svh @@
// Assertion macros shared by the PWM period and duty measurement RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PWM_PERIOD_DUTY_MEASURE_CORE_MACROS_SVH
`define PWM_PERIOD_DUTY_MEASURE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmd assertion failed");
// next-cycle implication
`define PMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmd assertion failed");
`else
`define PMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/pmd_pkg.sv @@
// Types and constants for the PWM period and duty measurement block.
// No dependencies; imported by every other RTL file but pmd_div.
package pmd_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int TICK_RATE_W     = 24;
    localparam int FREQ_W          = 23;
    localparam int DUTY_W          = 7;

    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 24'd1000000;
    localparam logic [DUTY_W-1:0]      DUTY_SCALE      = 7'd100;

    // input item codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_LOAD_F,
        ST_DIV_F,
        ST_LOAD_D,
        ST_DIV_D,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic arm;
        logic tick;
        logic load_high;
        logic load_low;
        logic bump_high;
        logic bump_low;
        logic div_start;
        logic div_duty;
        logic cap_freq;
        logic out_load;
    } pmd_cmd_t;

    typedef struct packed {
        logic rising;
        logic falling;
        logic div_done;
        logic div_busy;
        logic out_busy;
    } pmd_stat_t;

endpackage

@@ rtl/pmd_if.sv @@
// Valid/ready channel interfaces: input items, results and the config write.
// Depends on pmd_pkg for field widths.
interface pmd_item_if import pmd_pkg::*; ();
    logic valid;
    logic ready;
    logic cmd;
    logic level;

    modport source (output valid, output cmd, output level, input ready);
    modport sink (input valid, input cmd, input level, output ready);
endinterface

interface pmd_result_if import pmd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty_pct;
    logic              overflow;

    modport source (output valid, output freq_hz, output duty_pct, output overflow,
                    input ready);
    modport sink (input valid, input freq_hz, input duty_pct, input overflow,
                  output ready);
endinterface

interface pmd_cfg_if import pmd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [TICK_RATE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/pmd_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters; used by pmd_datapath.
module pmd_div #(
    parameter int DIVIDEND_W = 31,
    parameter int DIVISOR_W  = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits DIVISOR_W bits
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

@@ rtl/pmd_datapath.sv @@
// Datapath: edge detect, saturating tick counters, period and duty operands,
// shared divider and output register. Depends on pmd_pkg and pmd_div.
module pmd_datapath import pmd_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pmd_cmd_t               cmd,
    output pmd_stat_t              stat,
    input  logic                   level,
    input  logic                   cfg_we,
    input  logic [TICK_RATE_W-1:0] cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [FREQ_W-1:0]      freq_hz,
    output logic [DUTY_W-1:0]      duty_pct,
    output logic                   overflow
);
    localparam int PROD_W = COUNT_WIDTH + DUTY_W;
    localparam int DIV_W  = (PROD_W > TICK_RATE_W) ? PROD_W : TICK_RATE_W;
    localparam int PER_W  = COUNT_WIDTH + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [TICK_RATE_W-1:0] tick_rate_reg;
    logic                   prev_level_reg;
    logic [COUNT_WIDTH-1:0] high_reg;
    logic [COUNT_WIDTH-1:0] low_reg;
    logic                   sat_reg;
    logic                   out_valid_reg;
    logic [PER_W-1:0]       period_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [FREQ_W-1:0]      freq_reg;
    logic [FREQ_W-1:0]      out_freq_reg;
    logic [DUTY_W-1:0]      out_duty_reg;
    logic                   out_ovf_reg;
    logic [DIV_W-1:0]       dividend;
    logic [DIV_W-1:0]       quotient;
    logic                   div_busy;
    logic                   div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg  <= TICK_RATE_RESET;
            prev_level_reg <= 1'b0;
            high_reg       <= '0;
            low_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tick_rate_reg <= cfg_data;
            if (cmd.tick)
                prev_level_reg <= level;

            if (cmd.arm)
            begin
                high_reg <= '0;
                low_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.load_high)
                    high_reg <= COUNT_WIDTH'(1);
                else if (cmd.bump_high)
                begin
                    // hold at full scale and flag it
                    if (high_reg == COUNT_MAX)
                        sat_reg <= 1'b1;
                    else
                        high_reg <= high_reg + 1'b1;
                end
                if (cmd.load_low)
                    low_reg <= COUNT_WIDTH'(1);
                else if (cmd.bump_low)
                begin
                    if (low_reg == COUNT_MAX)
                        sat_reg <= 1'b1;
                    else
                        low_reg <= low_reg + 1'b1;
                end
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= PER_W'(high_reg) + PER_W'(low_reg);
        prod_reg   <= PROD_W'(high_reg) * PROD_W'(DUTY_SCALE);
        if (cmd.cap_freq)
            freq_reg <= quotient[FREQ_W-1:0];
        if (cmd.out_load)
        begin
            out_freq_reg <= freq_reg;
            out_duty_reg <= quotient[DUTY_W-1:0];
            out_ovf_reg  <= sat_reg;
        end
    end

    assign dividend = cmd.div_duty ? DIV_W'(prod_reg) : DIV_W'(tick_rate_reg);

    pmd_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (PER_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (period_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign stat.rising   = level & ~prev_level_reg;
    assign stat.falling  = ~level & prev_level_reg;
    assign stat.div_done = div_done;
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign freq_hz   = out_freq_reg;
    assign duty_pct  = out_duty_reg;
    assign overflow  = out_ovf_reg;
endmodule

@@ rtl/pmd_ctrl.sv @@
// Controller: measurement phase tracking and division sequencing.
// Depends on pmd_pkg; drives pmd_datapath through pmd_cmd_t.
module pmd_ctrl import pmd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_cmd,
    input  pmd_stat_t stat,
    output logic      item_ready,
    output pmd_cmd_t  cmd
);
    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_RUN:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_cmd == CMD_ARM)
                    begin
                        cmd.arm    = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        cmd.tick = 1'b1;
                        case (phase_reg)
                            PH_WAIT:
                            begin
                                if (stat.rising)
                                begin
                                    cmd.load_high = 1'b1;
                                    phase_next    = PH_HIGH;
                                end
                            end
                            PH_HIGH:
                            begin
                                if (stat.falling)
                                begin
                                    cmd.load_low = 1'b1;
                                    phase_next   = PH_LOW;
                                end
                                else
                                    cmd.bump_high = 1'b1;
                            end
                            PH_LOW:
                            begin
                                // second rising edge closes the period
                                if (stat.rising)
                                begin
                                    phase_next = PH_IDLE;
                                    state_next = ST_LOAD_F;
                                end
                                else
                                    cmd.bump_low = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_LOAD_F:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_F;
            end
            ST_DIV_F:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_freq = 1'b1;
                    state_next   = ST_LOAD_D;
                end
            end
            ST_LOAD_D:
            begin
                cmd.div_start = 1'b1;
                cmd.div_duty  = 1'b1;
                state_next    = ST_DIV_D;
            end
            ST_DIV_D:
            begin
                if (stat.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold the quotient until the output register frees up
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
                state_next = ST_RUN;
        endcase
    end
endmodule

@@ rtl/pwm_period_duty_measure_core.sv @@
// Top level of the PWM period and duty measurement block.
// Depends on pmd_pkg, pmd_if, pmd_ctrl, pmd_datapath and the macros header.
//
//   channel  dir  fields                          beat meaning
//   item     in   cmd, level                      one tick or an arm command
//   result   out  freq_hz, duty_pct, overflow     one finished measurement
//   cfg      in   data                            write of tick_rate_hz
//
// The tick that completes a period starts two passes, of DIV_W quotient bits each,
// through one shared bit-serial divider, DIV_W being the wider of COUNT_WIDTH+7
// and 24 (31 at the default width); item.ready is low until the result is loaded.
// Reset clears phase, counters and flags at once; tick_rate_hz returns to 1000000.
// Beats keep flowing while a result waits on result.ready; only a second result
// stalls, at the end of its division.
`include "pwm_period_duty_measure_core_macros.svh"
module pwm_period_duty_measure_core import pmd_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pmd_item_if.sink     item,
    pmd_result_if.source result,
    pmd_cfg_if.sink      cfg
);
    pmd_cmd_t  cmd;
    pmd_stat_t stat;

    assign cfg.ready = 1'b1;

    pmd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_cmd   (item.cmd),
        .stat       (stat),
        .item_ready (item.ready),
        .cmd        (cmd)
    );

    pmd_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .level     (item.level),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.data),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .freq_hz   (result.freq_hz),
        .duty_pct  (result.duty_pct),
        .overflow  (result.overflow)
    );

    `PMD_ASSERT_IMPLY(a_no_item_while_dividing, clk, rst_n, stat.div_busy, !item.ready)
    `PMD_ASSERT_IMPLY(a_start_on_idle_divider, clk, rst_n, cmd.div_start, !stat.div_busy)
    `PMD_ASSERT_IMPLY(a_load_free_slot, clk, rst_n, cmd.out_load, !(result.valid && !result.ready))
    `PMD_ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.out_load, result.valid)
endmodule

@@ dv/pmd_measure_check.sv @@
// Checker for the PWM period and duty measurement block: watches the item, config
// and result channels, predicts each finished measurement and compares it.
// Depends on pmd_pkg and the channel interfaces in pmd_if.
module pmd_measure_check import pmd_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    pmd_item_if   item,
    pmd_result_if result,
    pmd_cfg_if    cfg,
    output int    errors,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic              ovf;
    } meas_t;

    meas_t                  want_meas[$];
    phase_t                 cap_phase;
    logic                   last_lvl;
    logic [COUNT_WIDTH-1:0] hi_cnt;
    logic [COUNT_WIDTH-1:0] lo_cnt;
    logic                   sat;
    logic [TICK_RATE_W-1:0] rate;

    // Advance the capture state by one item beat; queue a measurement when a
    // period closes.
    task automatic advance_capture(input logic c, input logic lvl);
        logic               rise;
        logic               fall;
        logic [63:0]        span;
        meas_t              m;
        rise = lvl && !last_lvl;
        fall = !lvl && last_lvl;
        if (c == CMD_ARM)
        begin
            cap_phase = PH_WAIT;
            hi_cnt = '0;
            lo_cnt = '0;
            sat = 1'b0;
        end
        else
        begin
            case (cap_phase)
                PH_WAIT:
                begin
                    if (rise)
                    begin
                        hi_cnt = COUNT_WIDTH'(1);
                        cap_phase = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    if (fall)
                    begin
                        lo_cnt = COUNT_WIDTH'(1);
                        cap_phase = PH_LOW;
                    end
                    else if (&hi_cnt)
                        sat = 1'b1;
                    else
                        hi_cnt = hi_cnt + 1'b1;
                end
                PH_LOW:
                begin
                    if (rise)
                    begin
                        span = 64'(hi_cnt) + 64'(lo_cnt);
                        m.freq = FREQ_W'(64'(rate) / span);
                        m.duty = DUTY_W'((64'(hi_cnt) * 64'(DUTY_SCALE)) / span);
                        m.ovf = sat;
                        want_meas.push_back(m);
                        cap_phase = PH_IDLE;
                    end
                    else if (&lo_cnt)
                        sat = 1'b1;
                    else
                        lo_cnt = lo_cnt + 1'b1;
                end
                default: ;
            endcase
            last_lvl = lvl;
        end
    endtask

    task automatic compare_result();
        meas_t m;
        if (want_meas.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result freq=%0d duty=%0d overflow=%0b", $time,
                     result.freq_hz, result.duty_pct, result.overflow);
        end
        else
        begin
            m = want_meas.pop_front();
            if (result.freq_hz !== m.freq)
            begin
                errors++;
                $display("%0t: freq_hz expected %0d actual %0d", $time, m.freq,
                         result.freq_hz);
            end
            if (result.duty_pct !== m.duty)
            begin
                errors++;
                $display("%0t: duty_pct expected %0d actual %0d", $time, m.duty,
                         result.duty_pct);
            end
            if (result.overflow !== m.ovf)
            begin
                errors++;
                $display("%0t: overflow expected %0b actual %0b", $time, m.ovf,
                         result.overflow);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_meas.delete();
            cap_phase = PH_IDLE;
            last_lvl = 1'b0;
            hi_cnt = '0;
            lo_cnt = '0;
            sat = 1'b0;
            rate = TICK_RATE_RESET;
            errors = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                rate = cfg.data;
            if (item.valid && item.ready)
                advance_capture(item.cmd, item.level);
            if (result.valid && result.ready)
                compare_result();
        end
        pending = want_meas.size();
    end

endmodule

@@ dv/testbench.sv @@
// Top of the PWM period and duty measurement testbench: clock, reset, item and
// config stimulus, result back-pressure and the verdict.
// Depends on pmd_pkg, pmd_if, pmd_measure_check and the block itself.
module testbench import pmd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 2 * (COUNT_WIDTH_DEF + 7) + 40;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_ITEMS = 65;

    logic clk;
    logic rst_n;
    int   check_errors;
    int   meas_pending;
    int   sent_n;
    int   cycles;
    bit   src_idle_en;
    bit   sink_idle_en;
    bit   hold_req;

    pmd_item_if   item_ch ();
    pmd_result_if res_ch ();
    pmd_cfg_if    cfg_ch ();

    pwm_period_duty_measure_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(res_ch),
        .cfg   (cfg_ch)
    );

    pmd_measure_check u_check (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch),
        .errors (check_errors),
        .pending(meas_pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11)
            pick_gap = 0;
        else if (r < 18)
            pick_gap = $urandom_range(1, 3);
        else
            pick_gap = $urandom_range(8, 40);
    endfunction

    // Run length of one level: mostly short, now and then very long.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 49);
        if (r < 40)
            pick_len = $urandom_range(1, 6);
        else if (r < 48)
            pick_len = $urandom_range(7, 40);
        else
            pick_len = $urandom_range(100, 300);
    endfunction

    initial
    begin : result_drain
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    hold = HOLD_CYCLES;
                end
                else if (sink_idle_en)
                    hold = pick_gap();
            end
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic c, input logic lvl);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= c;
        item_ch.level <= lvl;
        do @(posedge clk); while (!item_ch.ready);
        sent_n++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_item(CMD_TICK, lvl);
    endtask

    // Arm, settle low, then one full period: high run, low run, closing edge.
    task automatic measure_once(input int hi_len, input int lo_len);
        send_item(CMD_ARM, logic'($urandom_range(0, 1)));
        send_run(1'b0, $urandom_range(0, 3));
        send_run(1'b1, hi_len);
        send_run(1'b0, lo_len);
        send_item(CMD_TICK, 1'b1);
    endtask

    // Drop valid, wait out every expected result and the divider.
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        wait (meas_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [TICK_RATE_W-1:0] r);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= r;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(input int goal);
        int r;
        while (sent_n < goal)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                measure_once(pick_len(), pick_len());
            else if (r < 9)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(($urandom_range(0, 7) == 0) ? CMD_ARM : CMD_TICK,
                              logic'($urandom_range(0, 1)));
            end
            else
            begin
                // abandon a measurement part way through
                send_item(CMD_ARM, logic'($urandom_range(0, 1)));
                send_run(1'b0, $urandom_range(0, 2));
                send_run(1'b1, pick_len());
                if ($urandom_range(0, 1))
                    send_run(1'b0, pick_len());
            end
        end
    endtask

    initial
    begin : stimulus
        logic [TICK_RATE_W-1:0] r;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_TICK;
        item_ch.level = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_req = 1'b0;
        sent_n = 0;
        cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ticks while idle, then the shortest period
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_ARM, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        // double arm, level already high at arm, restart while counting high
        send_item(CMD_ARM, 1'b1);
        send_item(CMD_ARM, 1'b0);
        send_run(1'b1, 2);
        send_item(CMD_TICK, 1'b0);
        send_run(1'b1, 2);
        send_item(CMD_ARM, 1'b1);
        send_item(CMD_TICK, 1'b0);
        send_run(1'b1, 3);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        // restart while counting low
        send_item(CMD_ARM, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_ARM, 1'b1);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_run(1'b0, 2);
        send_item(CMD_TICK, 1'b1);

        // zero rate gives zero frequency
        settle();
        write_rate('0);
        measure_once(1, 1);
        measure_once(3, 5);

        // full-scale rate, duty near both ends
        settle();
        write_rate('1);
        measure_once(1, 1);
        measure_once(49, 1);
        measure_once(1, 60);
        measure_once(30, 30);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: r = TICK_RATE_W'(1);
                1: r = '1;
                2: r = TICK_RATE_W'($urandom_range(2, 1000));
                3: r = TICK_RATE_W'($urandom_range(1, 16777215));
                4: r = '0;
                default: r = TICK_RATE_RESET;
            endcase
            write_rate(r);
            src_idle_en = (p != 0);
            sink_idle_en = (p != 0);
            if (p == 2)
            begin
                // hold results off while short periods keep coming
                hold_req = 1'b1;
                src_idle_en = 1'b0;
                repeat (20) measure_once(1, 1);
                src_idle_en = 1'b1;
            end
            random_phase(sent_n + PHASE_ITEMS);
        end

        settle();
        if (check_errors == 0 && meas_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pmd_pkg.sv
rtl/pmd_if.sv
rtl/pmd_div.sv
rtl/pmd_datapath.sv
rtl/pmd_ctrl.sv
rtl/pwm_period_duty_measure_core.sv
dv/pmd_measure_check.sv
dv/testbench.sv
